// ===== rtl/blaq_pkg.sv =====
// Shared types, constants and the full-scale table of the baseline averaging level quantizer.
package blaq_pkg;

   localparam int CHANNELS    = 16;
   localparam int SAMPLE_BITS = 10;
   localparam int CH_BITS     = 4;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AVG_BITS    = 10;
   localparam int LEVEL_BITS  = 3;
   localparam int PCT_BITS    = 7;
   localparam int FS_BITS     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int LEVEL_REGS  = 4;

   localparam int MEASURE_LEN = 10;
   localparam int CALIB_LEN   = 100;
   localparam int MCNT_W      = 4;
   localparam int CCNT_W      = 7;
   localparam int MSUM_W      = SAMPLE_BITS + 4;
   localparam int CSUM_W      = SAMPLE_BITS + 7;
   localparam int D_W         = SAMPLE_BITS + 9;
   localparam int THR_W       = PCT_BITS + FS_BITS;

   localparam int M_SHIFT     = 19;
   localparam int M_RECIP     = (1 << M_SHIFT) / MEASURE_LEN + 1;
   localparam int C_SHIFT     = 25;
   localparam int C_RECIP     = (1 << C_SHIFT) / CALIB_LEN + 1;
   localparam int RECIP_W     = $clog2(C_RECIP + 1);
   localparam int PROD_W      = CSUM_W + RECIP_W;

   localparam int MID_DEPTH   = 4;
   localparam int MID_PTR_W   = $clog2(MID_DEPTH);
   localparam int MID_CNT_W   = MID_PTR_W + 1;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = OUT_PTR_W + 1;

   localparam logic [PCT_BITS-1:0] LEVEL_ONE_RESET   = PCT_BITS'(35);
   localparam logic [PCT_BITS-1:0] LEVEL_TWO_RESET   = PCT_BITS'(50);
   localparam logic [PCT_BITS-1:0] LEVEL_THREE_RESET = PCT_BITS'(65);
   localparam logic [PCT_BITS-1:0] LEVEL_FOUR_RESET  = PCT_BITS'(80);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_ONE   = 2'd0,
      CSR_LEVEL_TWO   = 2'd1,
      CSR_LEVEL_THREE = 2'd2,
      CSR_LEVEL_FOUR  = 2'd3
   } csr_index_type;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO  = 3'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE   = 3'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_TWO   = 3'd2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_THREE = 3'd3;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FOUR  = 3'd4;

   localparam logic ACTION_MEASURE = 1'b0;
   localparam logic ACTION_CALIB   = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [CH_BITS-1:0]     channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    out_channel;
      logic [AVG_BITS-1:0]   average_reading;
      logic [LEVEL_BITS-1:0] level;
      logic                  from_calibration;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } head_type;

   typedef logic [LEVEL_REGS-1:0][PCT_BITS-1:0] thresholds_type;

   function automatic logic [FS_BITS-1:0] full_scale(input logic [CH_BITS-1:0] ch);
      logic [FS_BITS-1:0] fs;
      case (ch)
         4'd0: fs = 8'd36;
         4'd1: fs = 8'd15;
         4'd2: fs = 8'd15;
         4'd8: fs = 8'd200;
         4'd9: fs = 8'd206;
         default: fs = 8'd1;
      endcase
      return fs;
   endfunction

endpackage

// ===== rtl/blaq_front.sv =====
// Input side: accepts items, drops those for absent channels, and queues them for the back end.
module blaq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  blaq_pkg::req_item_type req_item,
   output blaq_pkg::head_type     head,
   input  logic                  take
);

   blaq_pkg::req_item_type            mem_ff [blaq_pkg::MID_DEPTH];
   logic [blaq_pkg::MID_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [blaq_pkg::MID_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [blaq_pkg::MID_CNT_W-1:0]    count_ff, count_in;
   logic                              in_range;
   logic                              write;
   logic                              read;

   assign full     = (count_ff == blaq_pkg::MID_CNT_W'(blaq_pkg::MID_DEPTH));
   assign in_range = ({1'b0, req_item.channel} < (blaq_pkg::CH_BITS + 1)'(blaq_pkg::CHANNELS));
   assign write    = push && !full && in_range;
   assign read     = take && (count_ff != '0);

   always_comb begin
      wr_ptr_in = write ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = read ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + blaq_pkg::MID_CNT_W'(write) - blaq_pkg::MID_CNT_W'(read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         mem_ff[wr_ptr_ff] <= req_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/blaq_back.sv =====
// Back end: per-channel window accumulation, then averaging and level grading in two stages.
module blaq_back (
   input  logic                                clock,
   input  logic                                reset,
   input  blaq_pkg::head_type                   head,
   output logic                                take,
   input  blaq_pkg::thresholds_type             thresholds,
   input  logic [blaq_pkg::OUT_CNT_W-1:0]       out_count,
   output logic                                rsp_write,
   output blaq_pkg::rsp_item_type               rsp_data
);

   logic [blaq_pkg::MSUM_W-1:0]    msum_ff [blaq_pkg::CHANNELS];
   logic [blaq_pkg::MCNT_W-1:0]    mcnt_ff [blaq_pkg::CHANNELS];
   logic [blaq_pkg::CSUM_W-1:0]    cacc_ff [blaq_pkg::CHANNELS];
   logic [blaq_pkg::CCNT_W-1:0]    ccnt_ff [blaq_pkg::CHANNELS];
   logic [blaq_pkg::CSUM_W-1:0]    base_ff [blaq_pkg::CHANNELS];

   logic [blaq_pkg::CH_IDX_W-1:0]  idx;
   logic [blaq_pkg::OUT_CNT_W:0]   used;
   logic [blaq_pkg::MSUM_W-1:0]    msum_in;
   logic [blaq_pkg::MCNT_W-1:0]    mcnt_in;
   logic [blaq_pkg::CSUM_W-1:0]    cacc_in;
   logic [blaq_pkg::CCNT_W-1:0]    ccnt_in;
   logic                           m_done;
   logic                           c_done;
   logic                           is_cal;

   logic                           a_valid_ff, a_valid_in;
   logic                           a_cal_ff;
   logic [blaq_pkg::CH_BITS-1:0]   a_ch_ff;
   logic [blaq_pkg::CSUM_W-1:0]    a_sum_ff, a_sum_in;
   logic [blaq_pkg::CSUM_W-1:0]    a_base_ff;
   logic [blaq_pkg::FS_BITS-1:0]   a_fs_ff;

   logic                           b_valid_ff;
   logic                           b_cal_ff;
   logic [blaq_pkg::CH_BITS-1:0]   b_ch_ff;
   logic [blaq_pkg::PROD_W-1:0]    b_prod_ff, b_prod_in;
   logic signed [blaq_pkg::D_W-1:0] b_d_ff, b_d_in;
   logic [blaq_pkg::LEVEL_REGS-1:0][blaq_pkg::THR_W-1:0] b_thr_ff, b_thr_in;

   logic [blaq_pkg::D_W-1:0]       ten_sum;
   logic [blaq_pkg::LEVEL_REGS-1:0] ge;
   logic [blaq_pkg::PROD_W-1:0]    avg_full;
   logic [blaq_pkg::LEVEL_BITS-1:0] level;

   assign idx    = head.item.channel[blaq_pkg::CH_IDX_W-1:0];
   assign is_cal = (head.item.action == blaq_pkg::ACTION_CALIB);

   always_comb begin
      used = {1'b0, out_count} + (blaq_pkg::OUT_CNT_W + 1)'(a_valid_ff)
           + (blaq_pkg::OUT_CNT_W + 1)'(b_valid_ff);
      take = head.valid && (used < (blaq_pkg::OUT_CNT_W + 1)'(blaq_pkg::OUT_DEPTH));
      msum_in = msum_ff[idx] + blaq_pkg::MSUM_W'(head.item.sample);
      mcnt_in = mcnt_ff[idx] + 1'b1;
      m_done  = (mcnt_in == blaq_pkg::MCNT_W'(blaq_pkg::MEASURE_LEN));
      cacc_in = cacc_ff[idx] + blaq_pkg::CSUM_W'(head.item.sample);
      ccnt_in = ccnt_ff[idx] + 1'b1;
      c_done  = (ccnt_in == blaq_pkg::CCNT_W'(blaq_pkg::CALIB_LEN));
      a_valid_in = take && (is_cal ? c_done : m_done);
      a_sum_in   = is_cal ? cacc_in : blaq_pkg::CSUM_W'(msum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < blaq_pkg::CHANNELS; i++) begin
            msum_ff[i] <= '0;
            mcnt_ff[i] <= '0;
            cacc_ff[i] <= '0;
            ccnt_ff[i] <= '0;
            base_ff[i] <= '0;
         end
      end else if (take) begin
         if (is_cal) begin
            cacc_ff[idx] <= c_done ? '0 : cacc_in;
            ccnt_ff[idx] <= c_done ? '0 : ccnt_in;
            if (c_done) begin
               base_ff[idx] <= cacc_in;
            end
         end else begin
            msum_ff[idx] <= m_done ? '0 : msum_in;
            mcnt_ff[idx] <= m_done ? '0 : mcnt_in;
         end
      end
   end

   always_comb begin
      ten_sum = (blaq_pkg::D_W'(a_sum_ff) << 3) + (blaq_pkg::D_W'(a_sum_ff) << 1);
      b_d_in  = $signed(ten_sum) - $signed(blaq_pkg::D_W'(a_base_ff));
      b_prod_in = blaq_pkg::PROD_W'(a_sum_ff) * (a_cal_ff
                ? blaq_pkg::PROD_W'(blaq_pkg::C_RECIP) : blaq_pkg::PROD_W'(blaq_pkg::M_RECIP));
      for (int i = 0; i < blaq_pkg::LEVEL_REGS; i++) begin
         b_thr_in[i] = blaq_pkg::THR_W'(thresholds[i]) * blaq_pkg::THR_W'(a_fs_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_in) begin
         a_cal_ff  <= is_cal;
         a_ch_ff   <= head.item.channel;
         a_sum_ff  <= a_sum_in;
         a_base_ff <= base_ff[idx];
         a_fs_ff   <= blaq_pkg::full_scale(head.item.channel);
      end
      if (a_valid_ff) begin
         b_cal_ff  <= a_cal_ff;
         b_ch_ff   <= a_ch_ff;
         b_prod_ff <= b_prod_in;
         b_d_ff    <= b_d_in;
         b_thr_ff  <= b_thr_in;
      end
   end

   always_comb begin
      for (int i = 0; i < blaq_pkg::LEVEL_REGS; i++) begin
         ge[i] = (b_d_ff >= $signed(blaq_pkg::D_W'(b_thr_ff[i])));
      end
      if (b_cal_ff || !ge[0]) begin
         level = blaq_pkg::LEVEL_ZERO;
      end else if (!ge[1]) begin
         level = blaq_pkg::LEVEL_ONE;
      end else if (!ge[2]) begin
         level = blaq_pkg::LEVEL_TWO;
      end else if (!ge[3]) begin
         level = blaq_pkg::LEVEL_THREE;
      end else begin
         level = blaq_pkg::LEVEL_FOUR;
      end
      avg_full = b_cal_ff ? (b_prod_ff >> blaq_pkg::C_SHIFT) : (b_prod_ff >> blaq_pkg::M_SHIFT);
      rsp_write                 = b_valid_ff;
      rsp_data.out_channel      = b_ch_ff;
      rsp_data.average_reading  = avg_full[blaq_pkg::AVG_BITS-1:0];
      rsp_data.level            = level;
      rsp_data.from_calibration = b_cal_ff;
   end

endmodule

// ===== rtl/blaq_out_fifo.sv =====
// Result queue that holds finished items until the receiver pops them.
module blaq_out_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_write,
   input  blaq_pkg::rsp_item_type          rsp_data,
   output logic [blaq_pkg::OUT_CNT_W-1:0] out_count,
   output logic                           empty,
   input  logic                           pop,
   output blaq_pkg::rsp_item_type          rsp_item
);

   blaq_pkg::rsp_item_type            mem_ff [blaq_pkg::OUT_DEPTH];
   logic [blaq_pkg::OUT_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [blaq_pkg::OUT_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [blaq_pkg::OUT_CNT_W-1:0]    count_ff, count_in;
   logic                              read;

   assign empty = (count_ff == '0);
   assign read  = pop && !empty;

   always_comb begin
      wr_ptr_in = rsp_write ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = read ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + blaq_pkg::OUT_CNT_W'(rsp_write) - blaq_pkg::OUT_CNT_W'(read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write) begin
         mem_ff[wr_ptr_ff] <= rsp_data;
      end
   end

   assign out_count = count_ff;
   assign rsp_item  = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/baseline_averaging_level_quantizer_unit.sv =====
// Top level of the baseline averaging level quantizer with its threshold registers.
// Usage: items (action, channel, sample) enter through push/full; an item is taken
// at a clock edge with push high and full low. Measure items fill a ten-sample
// window per channel, calibration items a hundred-sample window. Each completed
// window yields one result item (channel, average, level, calibration flag);
// other items yield nothing. Results leave through empty/pop, oldest first.
// Throughput is one item per cycle while the result queue has room: the per-channel
// accumulators are updated in the cycle an item leaves the input queue, and averaging
// plus level grading run in a two-stage pipeline behind it. A window's last item
// passes the input queue, stage a, stage b and the result queue before empty falls.
// When the receiver stalls, results collect in a four-entry result queue; the back
// end stops draining the four-entry input queue once results in flight would not
// fit, and full rises when that queue fills.
// Synchronous reset clears all sums, counts and baselines, empties both queues and
// loads the threshold registers with 35, 50, 65 and 80 percent. Threshold writes
// through csr_we/csr_index/csr_wdata take effect at once and belong in idle time.
module baseline_averaging_level_quantizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  blaq_pkg::req_item_type               req_item,
   output logic                                empty,
   input  logic                                pop,
   output blaq_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_we,
   input  logic [blaq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blaq_pkg::PCT_BITS-1:0]       csr_wdata
);

   blaq_pkg::thresholds_type          thr_ff;
   blaq_pkg::head_type                head;
   logic                              take;
   logic [blaq_pkg::OUT_CNT_W-1:0]    out_count;
   logic                              rsp_write;
   blaq_pkg::rsp_item_type            rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0] <= blaq_pkg::LEVEL_ONE_RESET;
         thr_ff[1] <= blaq_pkg::LEVEL_TWO_RESET;
         thr_ff[2] <= blaq_pkg::LEVEL_THREE_RESET;
         thr_ff[3] <= blaq_pkg::LEVEL_FOUR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            blaq_pkg::CSR_LEVEL_ONE:   thr_ff[0] <= csr_wdata;
            blaq_pkg::CSR_LEVEL_TWO:   thr_ff[1] <= csr_wdata;
            blaq_pkg::CSR_LEVEL_THREE: thr_ff[2] <= csr_wdata;
            blaq_pkg::CSR_LEVEL_FOUR:  thr_ff[3] <= csr_wdata;
            default: thr_ff <= thr_ff;
         endcase
      end
   end

   blaq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .head     (head),
      .take     (take)
   );

   blaq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .take       (take),
      .thresholds (thr_ff),
      .out_count  (out_count),
      .rsp_write  (rsp_write),
      .rsp_data   (rsp_data)
   );

   blaq_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .rsp_write (rsp_write),
      .rsp_data  (rsp_data),
      .out_count (out_count),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/blaq_checker.sv =====
// Port-level checks of the quantizer, attached to the top level by a bind statement.
module blaq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input blaq_pkg::rsp_item_type rsp_item
);

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.level <= blaq_pkg::LEVEL_FOUR))
      else $error("level code out of range");

   a_cal_level: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.from_calibration) |-> (rsp_item.level == blaq_pkg::LEVEL_ZERO))
      else $error("calibration item carries a nonzero level");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result item changed or vanished");

endmodule

bind baseline_averaging_level_quantizer_unit blaq_checker u_blaq_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
